[sv/trsp_pkg.sv]
package trsp_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned WordW  = 32;
    localparam int unsigned KindW  = 3;
    localparam int unsigned TypeW  = 4;
    localparam int unsigned ErrW   = 2;

    localparam logic [KindW-1:0] K_KEY   = 3'd0;
    localparam logic [KindW-1:0] K_VAL   = 3'd1;
    localparam logic [KindW-1:0] K_EMPTY = 3'd2;
    localparam logic [KindW-1:0] K_DONE  = 3'd3;
    localparam logic [KindW-1:0] K_ERR   = 3'd4;

    localparam logic [ErrW-1:0] E_MAGIC = 2'd0;
    localparam logic [ErrW-1:0] E_TYPE  = 2'd1;
    localparam logic [ErrW-1:0] E_TRUNC = 2'd2;

    localparam logic [TypeW-1:0] T_NONE   = 4'd0;
    localparam logic [TypeW-1:0] T_STRING = 4'd2;

    localparam logic [WordW-1:0] MagicReset = 32'd1;

    typedef enum logic [5:0] {
        PH_MAGIC  = 6'b000001,
        PH_TYPE   = 6'b000010,
        PH_KEYLEN = 6'b000100,
        PH_KEY    = 6'b001000,
        PH_STRLEN = 6'b010000,
        PH_VALUE  = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [ByteW-1:0] out_byte;
        logic [TypeW-1:0] value_type;
        logic             entry_last;
        logic [ErrW-1:0]  error_code;
        logic             run_last;
    } t_result;

    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_push;

    // payload size of a fixed-size type, zero when unknown
    function automatic logic [4:0] fixed_size(input logic [TypeW-1:0] t);
        logic [4:0] s;
        s = 5'd0;
        case (t)
            4'd1, 4'd5, 4'd9: s = 5'd4;
            4'd3:             s = 5'd8;
            4'd4:             s = 5'd12;
            4'd8:             s = 5'd16;
            default:          s = 5'd0;
        endcase
        return s;
    endfunction

endpackage

[sv/trsp_if.sv]
interface trsp_in_if;
    logic                         valid;
    logic                         ready;
    logic [trsp_pkg::ByteW-1:0]   in_byte;
    logic                         end_of_buffer;

    modport source (output valid, output in_byte, output end_of_buffer, input ready);
    modport sink (input valid, input in_byte, input end_of_buffer, output ready);
endinterface

interface trsp_out_if;
    logic                         valid;
    logic                         ready;
    logic [trsp_pkg::KindW-1:0]   kind;
    logic [trsp_pkg::ByteW-1:0]   out_byte;
    logic [trsp_pkg::TypeW-1:0]   value_type;
    logic                         entry_last;
    logic [trsp_pkg::ErrW-1:0]    error_code;
    logic                         run_last;

    modport source (output valid, output kind, output out_byte, output value_type,
                    output entry_last, output error_code, output run_last, input ready);
    modport sink (input valid, input kind, input out_byte, input value_type,
                  input entry_last, input error_code, input run_last, output ready);
endinterface

[sv/trsp_parse.sv]
module trsp_parse (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic [trsp_pkg::ByteW-1:0]   i_byte,
    input  logic                         i_eob,
    input  logic [trsp_pkg::WordW-1:0]   i_magic,
    output trsp_pkg::t_push              o_push
);

    trsp_pkg::t_phase              r_phase, n_phase;
    logic [1:0]                    r_idx, n_idx;
    logic [23:0]                   r_shift, n_shift;
    logic [trsp_pkg::TypeW-1:0]    r_type, n_type;
    logic [trsp_pkg::WordW-1:0]    r_left, n_left;
    logic                          r_stop, n_stop;

    logic [trsp_pkg::WordW-1:0]    word;
    logic                          word_done;
    logic [1:0]                    g_idx;
    logic [23:0]                   g_shift;
    logic                          known;
    logic                          key_fin;
    logic                          emit_a;
    logic                          emit_b;
    trsp_pkg::t_result             res_a;
    trsp_pkg::t_result             res_b;
    logic                          last_one;

    assign word      = {i_byte, r_shift};
    assign word_done = (r_idx == 2'd3);
    assign known     = (word[31:4] == 28'd0) &&
                       ((word[3:0] == trsp_pkg::T_STRING) ||
                        (trsp_pkg::fixed_size(word[3:0]) != 5'd0));
    assign last_one  = (r_left == 32'd1);

    always_comb begin
        g_shift = r_shift;
        g_idx   = r_idx + 2'd1;
        if (word_done) begin
            g_shift = 24'd0;
            g_idx   = 2'd0;
        end else begin
            case (r_idx)
                2'd0:    g_shift[7:0]   = i_byte;
                2'd1:    g_shift[15:8]  = i_byte;
                2'd2:    g_shift[23:16] = i_byte;
                default: g_shift        = r_shift;
            endcase
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_shift = r_shift;
        n_type  = r_type;
        n_left  = r_left;
        n_stop  = r_stop;
        key_fin = 1'b0;
        emit_a  = 1'b0;
        emit_b  = 1'b0;
        res_a   = '0;
        res_b   = '0;
        o_push  = '0;

        if (i_fire && !r_stop) begin
            unique case (r_phase)
                trsp_pkg::PH_MAGIC: begin
                    n_idx   = g_idx;
                    n_shift = g_shift;
                    if (word_done) begin
                        if (word != i_magic) begin
                            emit_a           = 1'b1;
                            res_a.kind       = trsp_pkg::K_ERR;
                            res_a.error_code = trsp_pkg::E_MAGIC;
                            n_stop           = 1'b1;
                        end else begin
                            n_phase = trsp_pkg::PH_TYPE;
                        end
                    end
                end
                trsp_pkg::PH_TYPE: begin
                    n_idx   = g_idx;
                    n_shift = g_shift;
                    if (word_done) begin
                        if (word == 32'd0) begin
                            emit_a     = 1'b1;
                            res_a.kind = trsp_pkg::K_DONE;
                            n_stop     = 1'b1;
                        end else begin
                            n_type  = known ? word[3:0] : trsp_pkg::T_NONE;
                            n_phase = trsp_pkg::PH_KEYLEN;
                        end
                    end
                end
                trsp_pkg::PH_KEYLEN: begin
                    n_idx   = g_idx;
                    n_shift = g_shift;
                    if (word_done) begin
                        n_left = word;
                        if (word == 32'd0) begin
                            key_fin = 1'b1;
                        end else begin
                            n_phase = trsp_pkg::PH_KEY;
                        end
                    end
                end
                trsp_pkg::PH_KEY: begin
                    if (r_type != trsp_pkg::T_NONE) begin
                        emit_a           = 1'b1;
                        res_a.kind       = trsp_pkg::K_KEY;
                        res_a.out_byte   = i_byte;
                        res_a.value_type = r_type;
                    end
                    n_left = r_left - 32'd1;
                    if (last_one) begin
                        key_fin = 1'b1;
                    end
                end
                trsp_pkg::PH_STRLEN: begin
                    n_idx   = g_idx;
                    n_shift = g_shift;
                    if (word_done) begin
                        if (word == 32'd0) begin
                            emit_a           = 1'b1;
                            res_a.kind       = trsp_pkg::K_EMPTY;
                            res_a.value_type = trsp_pkg::T_STRING;
                            res_a.entry_last = 1'b1;
                            n_phase          = trsp_pkg::PH_TYPE;
                        end else begin
                            n_left  = word;
                            n_phase = trsp_pkg::PH_VALUE;
                        end
                    end
                end
                trsp_pkg::PH_VALUE: begin
                    emit_a           = 1'b1;
                    res_a.kind       = trsp_pkg::K_VAL;
                    res_a.out_byte   = i_byte;
                    res_a.value_type = r_type;
                    res_a.entry_last = last_one;
                    n_left           = r_left - 32'd1;
                    if (last_one) begin
                        n_phase = trsp_pkg::PH_TYPE;
                    end
                end
                default: begin
                    n_phase = trsp_pkg::PH_MAGIC;
                end
            endcase

            // end of key
            if (key_fin) begin
                if (r_type == trsp_pkg::T_NONE) begin
                    emit_a           = 1'b1;
                    res_a.kind       = trsp_pkg::K_ERR;
                    res_a.error_code = trsp_pkg::E_TYPE;
                    n_stop           = 1'b1;
                end else if (r_type == trsp_pkg::T_STRING) begin
                    n_phase = trsp_pkg::PH_STRLEN;
                end else begin
                    n_left  = {27'd0, trsp_pkg::fixed_size(r_type)};
                    n_phase = trsp_pkg::PH_VALUE;
                end
            end
        end

        if (i_fire && i_eob) begin
            if (!n_stop) begin
                emit_b = 1'b1;
                if (n_phase == trsp_pkg::PH_TYPE && n_idx == 2'd0) begin
                    res_b.kind = trsp_pkg::K_DONE;
                end else begin
                    res_b.kind       = trsp_pkg::K_ERR;
                    res_b.error_code = trsp_pkg::E_TRUNC;
                end
            end
            n_phase = trsp_pkg::PH_MAGIC;
            n_idx   = 2'd0;
            n_shift = 24'd0;
            n_type  = trsp_pkg::T_NONE;
            n_left  = 32'd0;
            n_stop  = 1'b0;
        end

        res_b.run_last = 1'b1;
        res_a.run_last = !emit_b;
        if (emit_a && emit_b) begin
            o_push.num  = 2'd2;
            o_push.res0 = res_a;
            o_push.res1 = res_b;
        end else if (emit_a) begin
            o_push.num  = 2'd1;
            o_push.res0 = res_a;
        end else if (emit_b) begin
            o_push.num  = 2'd1;
            o_push.res0 = res_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= trsp_pkg::PH_MAGIC;
            r_idx   <= 2'd0;
            r_shift <= 24'd0;
            r_type  <= trsp_pkg::T_NONE;
            r_left  <= 32'd0;
            r_stop  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_shift <= n_shift;
            r_type  <= n_type;
            r_left  <= n_left;
            r_stop  <= n_stop;
        end
    end

endmodule

[sv/trsp_out_buf.sv]
module trsp_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push_en,
    input  trsp_pkg::t_push    i_push,
    input  logic               i_ready,
    output logic               o_space,
    output logic               o_valid,
    output trsp_pkg::t_result  o_head
);

    logic               r_v0, n_v0;
    logic               r_v1, n_v1;
    trsp_pkg::t_result  r_s0, n_s0;
    trsp_pkg::t_result  r_s1, n_s1;
    logic               pop;

    assign pop     = r_v0 && i_ready;
    assign o_space = !r_v0 || (pop && !r_v1);
    assign o_valid = r_v0;
    assign o_head  = r_s0;

    always_comb begin
        n_v0 = r_v0;
        n_v1 = r_v1;
        n_s0 = r_s0;
        n_s1 = r_s1;
        if (i_push_en) begin
            n_v0 = (i_push.num != 2'd0);
            n_v1 = (i_push.num == 2'd2);
            n_s0 = i_push.res0;
            n_s1 = i_push.res1;
        end else if (pop) begin
            n_v0 = r_v1;
            n_v1 = 1'b0;
            n_s0 = r_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
        end
        r_s0 <= n_s0;
        r_s1 <= n_s1;
    end

endmodule

[sv/tagged_record_stream_parser_core.sv]
// an accepted byte is held in the input register; its first result is registered in the output stage
// throughput: one byte per cycle while each byte gives at most one result and the output takes each result
// a byte that gives two results (last byte of a buffer) holds the result stage until both results are taken
// reset: synchronous active low; clears parser state and output stage, magic returns to 1
module tagged_record_stream_parser_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [trsp_pkg::WordW-1:0]  i_cfg_wdata,
    trsp_in_if.sink                     i_in,
    trsp_out_if.source                  o_out
);

    logic [trsp_pkg::WordW-1:0]  r_magic;
    logic                        r_in_v;
    logic [trsp_pkg::ByteW-1:0]  r_in_byte;
    logic                        r_in_eob;
    logic                        space;
    logic                        fire;
    trsp_pkg::t_push             push;
    trsp_pkg::t_result           head;
    logic                        head_v;

    assign fire       = r_in_v && space;
    assign i_in.ready = !r_in_v || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= trsp_pkg::MagicReset;
            r_in_v  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_magic <= i_cfg_wdata;
            end
            if (i_in.ready) begin
                r_in_v <= i_in.valid;
            end
        end
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.in_byte;
            r_in_eob  <= i_in.end_of_buffer;
        end
    end

    trsp_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .i_eob   (r_in_eob),
        .i_magic (r_magic),
        .o_push  (push)
    );

    trsp_out_buf u_out_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (fire),
        .i_push    (push),
        .i_ready   (o_out.ready),
        .o_space   (space),
        .o_valid   (head_v),
        .o_head    (head)
    );

    assign o_out.valid      = head_v;
    assign o_out.kind       = head.kind;
    assign o_out.out_byte   = head.out_byte;
    assign o_out.value_type = head.value_type;
    assign o_out.entry_last = head.entry_last;
    assign o_out.error_code = head.error_code;
    assign o_out.run_last   = head.run_last;

endmodule

[sv/trsp_checker.sv]
module trsp_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_ready,
    input  logic [trsp_pkg::KindW-1:0]  i_kind,
    input  logic [trsp_pkg::ByteW-1:0]  i_out_byte,
    input  logic [trsp_pkg::TypeW-1:0]  i_value_type,
    input  logic                        i_entry_last,
    input  logic [trsp_pkg::ErrW-1:0]   i_error_code,
    input  logic                        i_run_last
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    // stalled request holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_kind) && $stable(i_out_byte)
            && $stable(i_value_type) && $stable(i_error_code) && $stable(i_run_last))
        else $error("stalled result changed");

    // done and error carry no byte, type or entry end
    a_marker_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == trsp_pkg::K_DONE || i_kind == trsp_pkg::K_ERR)
            |-> i_out_byte == 8'd0 && i_value_type == 4'd0 && !i_entry_last)
        else $error("done or error with payload");

    // done and error always close the run of their byte
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == trsp_pkg::K_DONE || i_kind == trsp_pkg::K_ERR) |-> i_run_last)
        else $error("done or error not last of run");

    // error code only on errors
    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind != trsp_pkg::K_ERR |-> i_error_code == 2'd0)
        else $error("error code on non-error result");

endmodule

bind tagged_record_stream_parser_core trsp_checker u_trsp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_out.valid),
    .i_ready      (o_out.ready),
    .i_kind       (o_out.kind),
    .i_out_byte   (o_out.out_byte),
    .i_value_type (o_out.value_type),
    .i_entry_last (o_out.entry_last),
    .i_error_code (o_out.error_code),
    .i_run_last   (o_out.run_last)
);
